// File: hw/rtl/pclm_pkg.sv
`timescale 1ns / 1ps
package pclm_pkg;

  localparam int POOL_DEPTH_DEF = 128;

  // busy bitmap row geometry
  localparam int ROW_W    = 16;
  localparam int ROW_BITS = 4;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       find_grp;
    logic       find_word;
    logic       find_bit;
    logic       link1;
    logic       link2;
    logic       rm_read;
    logic       rm_commit;
    logic       finish;
    logic       st_we;
    logic [1:0] st_code;
  } ctl_t;

  typedef struct packed {
    logic pool_full;
    logic empty;
    logic rm_oob;
    logic slot_busy;
    logic last_node;
  } sts_t;

  // index of the lowest set bit, zero when none
  function automatic logic [ROW_BITS-1:0] lowest_set(input logic [ROW_W-1:0] v);
    logic [ROW_BITS-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) idx = ROW_BITS'(i);
    end
    return idx;
  endfunction

endpackage

// File: hw/rtl/pclm_ctrl.sv
`timescale 1ns / 1ps
module pclm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_command,
  input  pclm_pkg::sts_t   sts,
  output pclm_pkg::ctl_t   ctl,
  output logic             busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_GRP = 4'd1;
  localparam logic [3:0] S_A_WRD = 4'd2;
  localparam logic [3:0] S_A_BIT = 4'd3;
  localparam logic [3:0] S_A_LK1 = 4'd4;
  localparam logic [3:0] S_A_LK2 = 4'd5;
  localparam logic [3:0] S_R_RD  = 4'd6;
  localparam logic [3:0] S_R_CHK = 4'd7;
  localparam logic [3:0] S_CLR   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          unique case (in_command)
            pclm_pkg::CMD_APPEND: state_nxt = S_A_GRP;
            pclm_pkg::CMD_REMOVE: state_nxt = S_R_RD;
            pclm_pkg::CMD_CLEAR:  state_nxt = S_CLR;
            default:              state_nxt = S_FIN;
          endcase
        end
      end
      S_A_GRP: begin
        if (sts.pool_full) begin
          ctl.st_we   = 1'b1;
          ctl.st_code = pclm_pkg::ST_FULL;
          state_nxt   = S_FIN;
        end else begin
          ctl.find_grp = 1'b1;
          state_nxt    = S_A_WRD;
        end
      end
      S_A_WRD: begin
        ctl.find_word = 1'b1;
        state_nxt     = S_A_BIT;
      end
      S_A_BIT: begin
        ctl.find_bit = 1'b1;
        state_nxt    = S_A_LK1;
      end
      S_A_LK1: begin
        ctl.link1 = 1'b1;
        state_nxt = S_A_LK2;
      end
      S_A_LK2: begin
        ctl.link2 = 1'b1;
        state_nxt = S_FIN;
      end
      S_R_RD: begin
        priority if (sts.empty) begin
          ctl.st_we   = 1'b1;
          ctl.st_code = pclm_pkg::ST_EMPTY;
          state_nxt   = S_FIN;
        end else if (sts.rm_oob) begin
          ctl.st_we   = 1'b1;
          ctl.st_code = pclm_pkg::ST_NOT_USED;
          state_nxt   = S_FIN;
        end else begin
          ctl.rm_read = 1'b1;
          state_nxt   = S_R_CHK;
        end
      end
      S_R_CHK: begin
        if (!sts.slot_busy) begin
          ctl.st_we   = 1'b1;
          ctl.st_code = pclm_pkg::ST_NOT_USED;
        end else begin
          ctl.rm_commit = 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_CLR: begin
        ctl.clear = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ctl.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/pclm_dpath.sv
`timescale 1ns / 1ps
module pclm_dpath #(
  parameter int POOL_DEPTH = pclm_pkg::POOL_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pclm_pkg::ctl_t     ctl,
  output pclm_pkg::sts_t     sts,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_slot,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_slot_used,
  output logic [6:0]         out_head_slot,
  output logic               out_list_empty,
  output logic [7:0]         out_node_count
);

  localparam int RW    = pclm_pkg::ROW_W;
  localparam int RB    = pclm_pkg::ROW_BITS;
  localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int NW    = (POOL_DEPTH + RW - 1) / RW;
  localparam int WW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int NG    = (NW + RW - 1) / RW;
  localparam int GW    = (NG > 1) ? $clog2(NG) : 1;

  // storage
  logic [RW-1:0]     busy_mem [NW];
  logic [31:0]       val_mem  [POOL_DEPTH];
  logic [IDX_W-1:0]  prev_mem [POOL_DEPTH];
  logic [IDX_W-1:0]  next_mem [POOL_DEPTH];
  logic [NW-1:0]     busy_vld_r;
  logic [NW-1:0]     wfull_r;
  logic [NG-1:0]     gfull_r;

  // item and list registers
  logic signed [31:0] value_r;
  logic [6:0]         slot_r;
  logic [1:0]         status_r;
  logic [IDX_W-1:0]   used_r;
  logic [IDX_W-1:0]   head_r;
  logic               empty_r;
  logic [CNT_W-1:0]   count_r;
  logic [GW-1:0]      grp_r;
  logic [WW-1:0]      word_r;
  logic [IDX_W-1:0]   free_r;
  logic [RW-1:0]      busy_rd_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   prev_rd_r;
  logic [IDX_W-1:0]   next_rd_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [6:0]         out_slot_used_r;
  logic [6:0]         out_head_slot_r;
  logic               out_list_empty_r;
  logic [7:0]         out_node_count_r;

  // combinational
  logic [31:0]        slot32;
  logic [IDX_W-1:0]   slot_idx;
  logic [WW-1:0]      slot_word;
  logic [GW-1:0]      slot_grp;
  logic [RB-1:0]      slot_bit;
  logic [RW-1:0]      g16, w16, padw, cur_word, set_word, clr_word;
  logic [RB-1:0]      grp_pick, word_pick, bit_pick;
  logic [GW-1:0]      grp_sel;
  logic [WW-1:0]      word_sel;
  logic [IDX_W-1:0]   free_idx;
  logic [WW-1:0]      busy_ra;
  logic               prev_we, next_we;
  logic [IDX_W-1:0]   prev_wa, prev_wd, next_wa, next_wd;
  logic [IDX_W-1:0]   prev_ra;

  assign slot32    = 32'(slot_r);
  assign slot_idx  = IDX_W'(slot32);
  assign slot_word = WW'(slot32 >> RB);
  assign slot_grp  = GW'(slot32 >> (2 * RB));
  assign slot_bit  = slot32[RB-1:0];

  // group flags padded with full marks past the last group
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      g16[k] = (k < NG) ? gfull_r[GW'(k)] : 1'b1;
    end
  end
  assign grp_pick = pclm_pkg::lowest_set(~g16);
  assign grp_sel  = GW'(grp_pick);

  // word flags of the selected group, padded past the last word
  always_comb begin
    logic [31:0] widx;
    for (int k = 0; k < RW; k++) begin
      widx   = 32'(grp_r) * RW + 32'(k);
      w16[k] = (widx < NW) ? wfull_r[WW'(widx)] : 1'b1;
    end
  end
  assign word_pick = pclm_pkg::lowest_set(~w16);
  assign word_sel  = WW'(32'(grp_r) * RW + 32'(word_pick));

  // bits of the current row that lie past the pool
  always_comb begin
    for (int k = 0; k < RW; k++) begin
      padw[k] = (32'(word_r) * RW + 32'(k)) >= POOL_DEPTH;
    end
  end

  assign cur_word = rd_vld_r ? busy_rd_r : '0;
  assign bit_pick = pclm_pkg::lowest_set(~(cur_word | padw));
  assign free_idx = IDX_W'(32'(word_r) * RW + 32'(bit_pick));
  assign set_word = cur_word | (RW'(1) << bit_pick);
  assign clr_word = cur_word & ~(RW'(1) << slot_bit);

  assign sts.pool_full = &g16;
  assign sts.empty     = empty_r;
  assign sts.rm_oob    = slot32 >= POOL_DEPTH;
  assign sts.slot_busy = cur_word[slot_bit];
  assign sts.last_node = (count_r == CNT_W'(1));

  assign busy_ra = ctl.find_word ? word_sel : slot_word;
  assign prev_ra = ctl.rm_read ? slot_idx : head_r;

  // link write ports
  always_comb begin
    prev_we = 1'b0;
    prev_wa = free_r;
    prev_wd = free_r;
    next_we = 1'b0;
    next_wa = free_r;
    next_wd = free_r;
    if (ctl.link1) begin
      prev_we = 1'b1;
      next_we = 1'b1;
      if (!empty_r) begin
        prev_wa = head_r;
        next_wa = prev_rd_r;
      end
    end else if (ctl.link2) begin
      prev_we = !empty_r;
      prev_wd = prev_rd_r;
      next_we = !empty_r;
      next_wd = head_r;
    end else if (ctl.rm_commit && !sts.last_node) begin
      prev_we = 1'b1;
      prev_wa = next_rd_r;
      prev_wd = prev_rd_r;
      next_we = 1'b1;
      next_wa = prev_rd_r;
      next_wd = next_rd_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (ctl.find_word || ctl.rm_read) busy_rd_r <= busy_mem[busy_ra];
    if (ctl.find_bit)  busy_mem[word_r] <= set_word;
    if (ctl.rm_commit) busy_mem[word_r] <= clr_word;
  end

  always_ff @(posedge clk) begin
    if (ctl.find_grp || ctl.rm_read) prev_rd_r <= prev_mem[prev_ra];
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
  end

  always_ff @(posedge clk) begin
    if (ctl.rm_read) next_rd_r <= next_mem[slot_idx];
    if (next_we) next_mem[next_wa] <= next_wd;
  end

  always_ff @(posedge clk) begin
    if (ctl.link1) val_mem[free_r] <= value_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value_r <= in_value;
      slot_r  <= in_slot;
    end
    if (ctl.find_word || ctl.rm_read) rd_vld_r <= busy_vld_r[busy_ra];
    if (ctl.find_word) word_r <= word_sel;
    if (ctl.rm_read)   word_r <= slot_word;
    if (ctl.find_bit)  free_r <= free_idx;
  end

  // control and list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_vld_r  <= '0;
      wfull_r     <= '0;
      gfull_r     <= '0;
      grp_r       <= '0;
      head_r      <= '0;
      empty_r     <= 1'b1;
      count_r     <= '0;
      status_r    <= pclm_pkg::ST_OK;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
      if (ctl.load) begin
        status_r <= pclm_pkg::ST_OK;
        used_r   <= '0;
      end
      if (ctl.st_we) status_r <= ctl.st_code;
      if (ctl.clear) begin
        busy_vld_r <= '0;
        wfull_r    <= '0;
        gfull_r    <= '0;
        head_r     <= '0;
        empty_r    <= 1'b1;
        count_r    <= '0;
      end
      if (ctl.find_grp) grp_r <= grp_sel;
      if (ctl.rm_read)  grp_r <= slot_grp;
      if (ctl.find_bit) begin
        busy_vld_r[word_r] <= 1'b1;
        wfull_r[word_r]    <= &(set_word | padw);
      end
      if (ctl.link2) begin
        if (empty_r) begin
          head_r  <= free_r;
          empty_r <= 1'b0;
        end
        count_r <= count_r + CNT_W'(1);
        used_r  <= free_r;
      end
      if (ctl.rm_commit) begin
        busy_vld_r[word_r] <= 1'b1;
        wfull_r[word_r]    <= &(clr_word | padw);
        used_r             <= slot_idx;
        if (sts.last_node) begin
          head_r  <= '0;
          empty_r <= 1'b1;
          count_r <= '0;
        end else begin
          if (head_r == slot_idx) head_r <= next_rd_r;
          if (count_r != '0) count_r <= count_r - CNT_W'(1);
        end
      end
      // group flag follows its row flags
      if (ctl.finish) gfull_r[grp_r] <= &w16;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_status_r     <= status_r;
      out_slot_used_r  <= 7'(32'(used_r));
      out_head_slot_r  <= 7'(32'(head_r));
      out_list_empty_r <= empty_r;
      out_node_count_r <= 8'(32'(count_r));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_used  = out_slot_used_r;
  assign out_head_slot  = out_head_slot_r;
  assign out_list_empty = out_list_empty_r;
  assign out_node_count = out_node_count_r;

endmodule

// File: hw/rtl/pooled_circular_list_manager_top.sv
`timescale 1ns / 1ps
// start to result strobe: append walks group, row and bit search then two link steps;
// remove reads then commits; clear empties; others go straight to finish; pool full or a
// remove refused at the first check ends there, an unused slot after the read; one command
// at a time, paced by the three-level bitmap search and each link memory's one write port
// the receiver cannot stall: each result word shows on out_* for one cycle under out_valid
// synchronous active-low reset empties the list; no clearing pass, ready right after reset
module pooled_circular_list_manager_top #(
  parameter int POOL_DEPTH = pclm_pkg::POOL_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_slot,
  // result side
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_slot_used,
  output logic [6:0]         out_head_slot,
  output logic               out_list_empty,
  output logic [7:0]         out_node_count
);

  // command strobes from the sequencer, condition flags back from the datapath
  pclm_pkg::ctl_t ctl;
  pclm_pkg::sts_t sts;

  // sequencer: append walks group, row and bit search then two link steps,
  // remove reads the slot row and both links then commits in one step
  pclm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  // datapath: busy bitmap rows with row and group full flags, link and value
  // memories, head and count, registered result word
  pclm_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_value       (in_value),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_used  (out_slot_used),
    .out_head_slot  (out_head_slot),
    .out_list_empty (out_list_empty),
    .out_node_count (out_node_count)
  );

endmodule
